FILE: rtl/bgns_pkg.sv
// ----------------------------------------------------------------------------
// Bitsliced Gaussian noise sampler package
// Shared constants, types and the per-set Boolean plane functions.
// ----------------------------------------------------------------------------
package bgns_pkg;

	localparam int LANES_DEF        = 64;
	localparam int MAX_WORDS        = 12;
	localparam int CNT_W            = 4;
	localparam int SHIFT_W          = 4;
	localparam int SET_W            = 2;
	localparam int COEFF_W          = 16;
	localparam int CFG_IDX_W        = 1;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SET   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_SHIFT = 1'b1;

	// Noise set codes.
	localparam logic [SET_W-1:0] SET_D1 = 2'd0;
	localparam logic [SET_W-1:0] SET_D2 = 2'd1;
	localparam logic [SET_W-1:0] SET_D3 = 2'd2;
	localparam logic [SET_W-1:0] SET_D4 = 2'd3;

	// Number of words in a group for each set.
	function automatic logic [CNT_W-1:0] group_len(input logic [SET_W-1:0] s);
		logic [CNT_W-1:0] r;
		unique case (s)
			SET_D1:  r = 4'd10;
			SET_D2:  r = 4'd11;
			SET_D3:  r = 4'd12;
			default: r = 4'd11;
		endcase
		return r;
	endfunction

	// Magnitude bits of one lane: w holds bit k of each of the group's words.
	function automatic logic [3:0] lane_mag(input logic [SET_W-1:0] s,
			input logic [MAX_WORDS-1:0] w);
		logic [3:0] b;
		b = '0;
		unique case (s)
			SET_D1: begin
				b[0] = (w[0]&w[1]&w[2]&w[3]&w[4]&w[5]&w[7]&~w[8]) |
					(w[0]&w[3]&w[4]&w[5]&w[6]&w[8]) | (w[1]&w[3]&w[4]&w[5]&w[6]&w[8]) |
					(w[2]&w[3]&w[4]&w[5]&w[6]&w[8]) |
					(~w[2]&~w[3]&~w[6]&w[8]) | (~w[1]&~w[3]&~w[6]&w[8]) |
					(w[6]&w[7]&~w[8]) | (~w[5]&~w[6]&w[8]) |
					(~w[4]&~w[6]&w[8]) | (~w[7]&w[8]);
				b[1] = (w[1]&w[2]&w[4]&w[5]&w[7]&w[8]) |
					(w[3]&w[4]&w[5]&w[7]&w[8]) | (w[6]&w[7]&w[8]);
			end
			SET_D2: begin
				b[0] = (w[0]&w[1]&w[2]&w[3]&w[5]&w[7]&w[8]) |
					(w[1]&w[2]&w[3]&w[5]&~w[6]&w[7]&w[9]) |
					(~w[1]&~w[2]&~w[3]&w[6]&w[7]&w[8]) |
					(~w[1]&~w[2]&~w[3]&~w[5]&~w[8]&w[9]) |
					(~w[0]&~w[2]&~w[3]&~w[5]&~w[8]&w[9]) |
					(w[4]&w[5]&~w[6]&w[7]&w[9]) |
					(w[3]&w[4]&w[8]&~w[9]) | (~w[5]&w[6]&w[7]&w[8]) |
					(~w[4]&w[6]&w[7]&w[8]) | (~w[4]&~w[5]&~w[8]&w[9]) |
					(w[5]&w[8]&~w[9]) | (w[6]&w[8]&~w[9]) |
					(w[7]&w[8]&~w[9]) | (~w[7]&~w[8]&w[9]) | (~w[6]&~w[8]&w[9]);
				b[1] = (w[0]&w[1]&w[4]&~w[5]&w[6]&w[7]&w[9]) |
					(w[2]&w[4]&~w[5]&w[6]&w[7]&w[9]) |
					(w[3]&w[4]&~w[5]&w[6]&w[7]&w[9]) |
					(w[5]&w[6]&w[7]&~w[8]&w[9]) |
					(~w[1]&~w[2]&~w[3]&w[8]&w[9]) | (~w[7]&w[8]&w[9]) |
					(~w[6]&w[8]&w[9]) | (~w[5]&w[8]&w[9]) | (~w[4]&w[8]&w[9]);
				b[2] = (w[1]&w[4]&w[5]&w[6]&w[7]&w[8]&w[9]) |
					(w[2]&w[4]&w[5]&w[6]&w[7]&w[8]&w[9]) |
					(w[3]&w[4]&w[5]&w[6]&w[7]&w[8]&w[9]);
			end
			SET_D3: begin
				b[0] = (w[0]&~w[2]&~w[3]&w[4]&w[6]&w[7]&w[9]) |
					(w[1]&~w[2]&~w[3]&w[4]&w[6]&w[7]&w[9]) |
					(~w[0]&~w[1]&~w[3]&w[5]&w[6]&w[7]&w[9]) |
					(w[1]&w[2]&w[3]&w[5]&w[6]&w[7]&w[9]) |
					(~w[1]&~w[2]&~w[3]&~w[4]&~w[7]&w[8]&w[9]) |
					(w[2]&w[4]&~w[5]&w[6]&w[8]&w[9]) |
					(~w[3]&~w[4]&~w[7]&~w[8]&~w[9]&w[10]) |
					(w[3]&w[4]&w[7]&w[8]&~w[10]) |
					(w[3]&w[4]&~w[5]&w[6]&w[9]) |
					(~w[4]&w[5]&w[6]&w[7]&w[9]) |
					(~w[6]&~w[7]&~w[8]&~w[9]&w[10]) |
					(~w[5]&~w[7]&~w[8]&~w[9]&w[10]) |
					(w[5]&w[7]&w[8]&~w[10]) | (w[6]&w[7]&w[8]&~w[10]) |
					(w[5]&w[6]&~w[8]&w[9]) | (~w[6]&~w[7]&w[8]&w[9]) |
					(~w[5]&~w[7]&w[8]&w[9]) | (w[7]&~w[8]&w[9]) | (w[9]&~w[10]);
				b[1] = (w[0]&w[2]&w[4]&w[5]&w[6]&w[7]&w[10]) |
					(w[1]&w[2]&w[4]&w[5]&w[6]&w[7]&w[10]) |
					(~w[1]&~w[2]&~w[3]&~w[4]&~w[7]&w[9]&w[10]) |
					(w[3]&w[4]&w[5]&w[6]&w[7]&w[10]) |
					(w[3]&w[5]&w[6]&~w[8]&w[10]) |
					(w[4]&w[5]&w[6]&~w[8]&w[10]) |
					(~w[6]&~w[7]&w[9]&w[10]) | (~w[5]&~w[7]&w[9]&w[10]) |
					(w[7]&~w[8]&w[10]) | (w[8]&~w[9]&w[10]) | (~w[8]&w[9]&w[10]);
				b[2] = (w[1]&w[5]&w[6]&w[8]&w[9]&w[10]) |
					(w[2]&w[5]&w[6]&w[8]&w[9]&w[10]) |
					(w[3]&w[5]&w[6]&w[8]&w[9]&w[10]) |
					(w[4]&w[5]&w[6]&w[8]&w[9]&w[10]) | (w[7]&w[8]&w[9]&w[10]);
			end
			default: begin
				b[0] = (w[0]&w[1]&~w[2]&w[3]&w[4]&~w[6]&w[7]&~w[9]) |
					(w[2]&w[3]&w[4]&~w[5]&~w[6]&w[7]&~w[9]) |
					(~w[2]&~w[3]&~w[4]&~w[5]&~w[7]&w[8]) |
					(~w[1]&~w[3]&~w[4]&~w[5]&~w[7]&w[8]) |
					(~w[0]&~w[3]&~w[4]&~w[5]&~w[7]&w[8]) |
					(w[0]&~w[2]&w[3]&w[5]&~w[6]&w[8]) |
					(w[1]&~w[2]&w[3]&w[5]&~w[6]&w[8]) |
					(w[2]&w[3]&~w[4]&w[5]&~w[6]&w[8]) |
					(w[0]&w[1]&w[4]&w[5]&w[7]&w[9]) |
					(w[2]&~w[3]&w[4]&w[6]&w[7]&w[9]) |
					(~w[2]&w[3]&w[4]&w[6]&w[7]&w[9]) |
					(~w[3]&w[5]&~w[6]&w[7]&~w[9]) |
					(w[0]&w[2]&w[5]&w[7]&~w[8]) | (w[1]&w[2]&w[5]&w[7]&~w[8]) |
					(w[4]&w[5]&~w[6]&w[7]&w[9]) | (~w[4]&~w[5]&w[6]&w[7]&w[9]) |
					(~w[2]&~w[5]&w[6]&w[7]&w[9]) |
					(w[3]&w[5]&w[7]&~w[8]) | (~w[5]&~w[6]&w[8]&~w[9]) |
					(~w[2]&~w[6]&w[8]&~w[9]) | (w[6]&w[7]&~w[8]) |
					(~w[7]&w[8]&~w[9]) | (~w[6]&~w[7]&w[8]);
				b[1] = (w[2]&w[3]&w[4]&w[5]&w[7]&w[8]&~w[9]) |
					(w[2]&w[3]&w[4]&~w[5]&w[6]&w[7]&w[9]) |
					(~w[2]&~w[3]&~w[4]&~w[5]&~w[7]&w[9]) |
					(~w[1]&~w[3]&~w[4]&~w[5]&~w[7]&w[9]) |
					(~w[0]&~w[3]&~w[4]&~w[5]&~w[7]&w[9]) |
					(~w[4]&w[5]&w[6]&w[7]&w[9]) | (~w[3]&w[5]&w[6]&w[7]&w[9]) |
					(~w[2]&w[5]&w[6]&w[7]&w[9]) |
					(w[6]&w[7]&w[8]&~w[9]) | (~w[6]&~w[7]&w[9]) | (~w[8]&w[9]);
				b[2] = (w[0]&w[1]&w[2]&~w[3]&w[6]&w[8]&w[9]) |
					(w[3]&w[6]&~w[7]&w[8]&w[9]) | (w[4]&~w[5]&w[6]&w[8]&w[9]) |
					(~w[3]&w[5]&w[6]&w[8]&w[9]) |
					(~w[6]&w[7]&w[8]&w[9]) | (~w[4]&w[7]&w[8]&w[9]) |
					(~w[2]&w[7]&w[8]&w[9]);
				b[3] = w[2]&w[3]&w[4]&w[5]&w[6]&w[7]&w[8]&w[9];
			end
		endcase
		return b;
	endfunction

	// Control of one finished group, handed from the front to the queue.
	typedef struct packed {
		logic [SET_W-1:0]   noise_set;
		logic [SHIFT_W-1:0] shift;
	} grp_ctl_t;

endpackage

FILE: rtl/bgns_front.sv
// ----------------------------------------------------------------------------
// Bitsliced Gaussian noise sampler front end
// Collects words into groups and hands a full group to the group queue.
// ----------------------------------------------------------------------------
module bgns_front #(
	parameter int LANES = bgns_pkg::LANES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [bgns_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [bgns_pkg::SHIFT_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [LANES-1:0]                    in_word,
	// Full group: every word, with its control.
	output logic                                grp_valid,
	input  logic                                grp_ready,
	output logic [bgns_pkg::MAX_WORDS*LANES-1:0] grp_words,
	output bgns_pkg::grp_ctl_t                  grp_ctl
);
	import bgns_pkg::*;

	logic [LANES-1:0]   store_q [MAX_WORDS];
	logic [CNT_W-1:0]   count_q;
	logic [SET_W-1:0]   set_q;
	logic [SHIFT_W-1:0] shift_q;
	logic               last_word;
	logic               take;

	// A word is taken unless a completed group cannot be handed on.
	assign last_word = (count_q == group_len(set_q) - 4'd1);
	assign in_ready  = !last_word || grp_ready;
	assign take      = in_valid && in_ready;
	assign grp_valid = in_valid && last_word;

	// Registers and word count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			set_q   <= SET_D1;
			shift_q <= SHIFT_RESET;
		end else begin
			if (take) begin
				count_q <= last_word ? '0 : count_q + 4'd1;
			end
			if (cfg_wr && cfg_idx == REG_NOISE_SET) begin
				set_q   <= cfg_data[SET_W-1:0];
				count_q <= '0;
			end
			if (cfg_wr && cfg_idx == REG_COEFF_SHIFT) begin
				shift_q <= cfg_data;
			end
		end
	end

	// Word store.
	always_ff @(posedge clk) begin
		if (take && !last_word) begin
			store_q[count_q] <= in_word;
		end
	end

	// The group's last word joins the stored ones; it sits at its own slot.
	always_comb begin
		for (int j = 0; j < MAX_WORDS; j++) begin
			grp_words[j*LANES +: LANES] = (CNT_W'(j) == count_q) ? in_word : store_q[j];
		end
		grp_ctl.noise_set = set_q;
		grp_ctl.shift     = shift_q;
	end

endmodule

FILE: rtl/bgns_queue.sv
// ----------------------------------------------------------------------------
// Bitsliced Gaussian noise sampler group queue
// Two-entry queue of evaluated groups between the front and back ends.
// ----------------------------------------------------------------------------
module bgns_queue #(
	parameter int LANES = bgns_pkg::LANES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_valid,
	output logic                         wr_ready,
	input  logic [bgns_pkg::MAX_WORDS*LANES-1:0] wr_words,
	input  bgns_pkg::grp_ctl_t           wr_ctl,
	output logic                         rd_valid,
	input  logic                         rd_ready,
	output logic [4*LANES-1:0]           rd_mag,
	output logic [LANES-1:0]             rd_sign,
	output logic [bgns_pkg::SHIFT_W-1:0] rd_shift
);
	import bgns_pkg::*;

	localparam int ENT_W = 5 * LANES + SHIFT_W;

	logic [ENT_W-1:0] ent_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       fill_q;
	logic [ENT_W-1:0] wr_ent;
	logic [LANES-1:0] sgn;
	logic [4*LANES-1:0] mag;
	logic [CNT_W-1:0] sidx;

	// Evaluate the plane functions lane by lane as the group enters.
	always_comb begin
		logic [MAX_WORDS-1:0] w;
		logic [3:0] m;
		sidx = group_len(wr_ctl.noise_set) - 4'd1;
		for (int k = 0; k < LANES; k++) begin
			for (int j = 0; j < MAX_WORDS; j++) begin
				w[j] = wr_words[j*LANES + k];
			end
			m = lane_mag(wr_ctl.noise_set, w);
			mag[4*k +: 4] = m;
			sgn[k] = w[sidx];
		end
	end

	assign wr_ent   = {wr_ctl.shift, sgn, mag};
	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign {rd_shift, rd_sign, rd_mag} = ent_q[rp_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) ent_q[wp_q] <= wr_ent;
	end

endmodule

FILE: rtl/bgns_back.sv
// ----------------------------------------------------------------------------
// Bitsliced Gaussian noise sampler back end
// Walks a queued group's lanes: one coefficient per cycle unless stalled.
// ----------------------------------------------------------------------------
module bgns_back #(
	parameter int LANES = bgns_pkg::LANES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         grp_valid,
	output logic                         grp_ready,
	input  logic [4*LANES-1:0]           grp_mag,
	input  logic [LANES-1:0]             grp_sign,
	input  logic [bgns_pkg::SHIFT_W-1:0] grp_shift,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bgns_pkg::COEFF_W-1:0] out_coeff,
	output logic                         out_last
);
	import bgns_pkg::*;

	localparam int LW = $clog2(LANES);

	logic [LW-1:0]      lane_q;
	logic               ovalid_q;
	logic [COEFF_W-1:0] coeff_q;
	logic               last_q;
	logic               load;
	logic [3:0]         m;
	logic               s;
	logic [COEFF_W-1:0] sv;

	// Output register is loaded when empty or being drained.
	assign load      = grp_valid && (!ovalid_q || out_ready);
	assign grp_ready = load && (lane_q == LW'(LANES - 1));
	assign m  = grp_mag[4*lane_q +: 4];
	assign s  = grp_sign[lane_q];
	assign sv = ({{(COEFF_W-4){1'b0}}, m} ^ {COEFF_W{s}}) + {{(COEFF_W-1){1'b0}}, s};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				lane_q   <= lane_q + 1'b1;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coeff_q <= sv << grp_shift;
			last_q  <= (lane_q == LW'(LANES - 1));
		end
	end

	assign out_valid = ovalid_q;
	assign out_coeff = coeff_q;
	assign out_last  = last_q;

endmodule

FILE: rtl/bitsliced_gaussian_noise_sampler_top.sv
// ----------------------------------------------------------------------------
// Bitsliced Gaussian noise sampler
// Groups random words per noise set and emits 64 signed, shifted samples.
// ----------------------------------------------------------------------------
// On a group's last word the set's Boolean functions are evaluated across
// the group and the lane magnitudes and signs enter a two-entry queue; the
// back end then emits one coefficient per cycle unless stalled, 64 per group
// of 10 to 12 words, so sustained throughput is set by that output walk.
module bitsliced_gaussian_noise_sampler_top #(
	parameter int LANES = bgns_pkg::LANES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bgns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgns_pkg::SHIFT_W-1:0] cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [LANES-1:0]             s_axis_tdata,  // random_word
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [bgns_pkg::COEFF_W-1:0] m_axis_tdata,  // coefficient
	output logic                         m_axis_tlast   // last_of_group
);
	import bgns_pkg::*;

	logic                         g_valid, g_ready;
	logic [MAX_WORDS*LANES-1:0]   g_words;
	grp_ctl_t                     g_ctl;
	logic                         q_valid, q_ready;
	logic [4*LANES-1:0]           q_mag;
	logic [LANES-1:0]             q_sign;
	logic [SHIFT_W-1:0]           q_shift;

	bgns_front #(.LANES(LANES)) u_front (
		.clk, .arst_n,
		.cfg_wr(cfg_we), .cfg_idx(cfg_index), .cfg_data,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_word(s_axis_tdata),
		.grp_valid(g_valid), .grp_ready(g_ready), .grp_words(g_words), .grp_ctl(g_ctl)
	);

	bgns_queue #(.LANES(LANES)) u_queue (
		.clk, .arst_n,
		.wr_valid(g_valid), .wr_ready(g_ready), .wr_words(g_words), .wr_ctl(g_ctl),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_mag(q_mag), .rd_sign(q_sign),
		.rd_shift(q_shift)
	);

	bgns_back #(.LANES(LANES)) u_back (
		.clk, .arst_n,
		.grp_valid(q_valid), .grp_ready(q_ready), .grp_mag(q_mag), .grp_sign(q_sign),
		.grp_shift(q_shift),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_coeff(m_axis_tdata), .out_last(m_axis_tlast)
	);

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the bitsliced Gaussian noise sampler
// Streams random words in groups, predicts the 64 coefficients of each group
// and checks every output item against that prediction in order.
// ----------------------------------------------------------------------------
module tb;
	import bgns_pkg::*;

	typedef struct {
		logic [COEFF_W-1:0] coeff;
		logic               last;
	} coeff_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SHIFT_W-1:0]   cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [63:0]          s_axis_tdata;   // random_word
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [COEFF_W-1:0]   m_axis_tdata;   // coefficient
	logic                 m_axis_tlast;   // last_of_group

	bitsliced_gaussian_noise_sampler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// Words waiting to be sent and coefficients waiting to arrive.
	logic [63:0]  word_queue[$];
	coeff_item_t  coeff_queue[$];

	// Own copy of the block's state and registers.
	logic [63:0]        grp_words[MAX_WORDS];
	int                 grp_fill;
	logic [SET_W-1:0]   cur_set;
	logic [SHIFT_W-1:0] cur_shift;

	int src_idle_pct;
	int dst_idle_pct;
	int errors;
	int groups_seen;
	int coeffs_seen;
	logic took;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#5000000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic int words_in_group(input logic [SET_W-1:0] s);
		case (s)
			SET_D1:  return 10;
			SET_D2:  return 11;
			SET_D3:  return 12;
			default: return 11;
		endcase
	endfunction

	// Bit plane j of the magnitudes of all 64 lanes for the current group.
	function automatic logic [63:0] mag_plane(input logic [SET_W-1:0] s, input int j);
		logic [63:0] w0, w1, w2, w3, w4, w5, w6, w7, w8, w9, w10;
		logic [63:0] r;
		w0 = grp_words[0]; w1 = grp_words[1]; w2 = grp_words[2]; w3 = grp_words[3];
		w4 = grp_words[4]; w5 = grp_words[5]; w6 = grp_words[6]; w7 = grp_words[7];
		w8 = grp_words[8]; w9 = grp_words[9]; w10 = grp_words[10];
		r = '0;
		case (s)
			SET_D1: begin
				if (j == 0)
					r = (w0 & w1 & w2 & w3 & w4 & w5 & w7 & ~w8) |
						(w0 & w3 & w4 & w5 & w6 & w8) | (w1 & w3 & w4 & w5 & w6 & w8) |
						(w2 & w3 & w4 & w5 & w6 & w8) |
						(~w2 & ~w3 & ~w6 & w8) | (~w1 & ~w3 & ~w6 & w8) |
						(w6 & w7 & ~w8) | (~w5 & ~w6 & w8) |
						(~w4 & ~w6 & w8) | (~w7 & w8);
				else if (j == 1)
					r = (w1 & w2 & w4 & w5 & w7 & w8) |
						(w3 & w4 & w5 & w7 & w8) | (w6 & w7 & w8);
			end
			SET_D2: begin
				if (j == 0)
					r = (w0 & w1 & w2 & w3 & w5 & w7 & w8) |
						(w1 & w2 & w3 & w5 & ~w6 & w7 & w9) |
						(~w1 & ~w2 & ~w3 & w6 & w7 & w8) |
						(~w1 & ~w2 & ~w3 & ~w5 & ~w8 & w9) |
						(~w0 & ~w2 & ~w3 & ~w5 & ~w8 & w9) |
						(w4 & w5 & ~w6 & w7 & w9) |
						(w3 & w4 & w8 & ~w9) | (~w5 & w6 & w7 & w8) |
						(~w4 & w6 & w7 & w8) | (~w4 & ~w5 & ~w8 & w9) |
						(w5 & w8 & ~w9) | (w6 & w8 & ~w9) |
						(w7 & w8 & ~w9) | (~w7 & ~w8 & w9) | (~w6 & ~w8 & w9);
				else if (j == 1)
					r = (w0 & w1 & w4 & ~w5 & w6 & w7 & w9) |
						(w2 & w4 & ~w5 & w6 & w7 & w9) |
						(w3 & w4 & ~w5 & w6 & w7 & w9) |
						(w5 & w6 & w7 & ~w8 & w9) |
						(~w1 & ~w2 & ~w3 & w8 & w9) | (~w7 & w8 & w9) |
						(~w6 & w8 & w9) | (~w5 & w8 & w9) | (~w4 & w8 & w9);
				else if (j == 2)
					r = (w1 & w4 & w5 & w6 & w7 & w8 & w9) |
						(w2 & w4 & w5 & w6 & w7 & w8 & w9) |
						(w3 & w4 & w5 & w6 & w7 & w8 & w9);
			end
			SET_D3: begin
				if (j == 0)
					r = (w0 & ~w2 & ~w3 & w4 & w6 & w7 & w9) |
						(w1 & ~w2 & ~w3 & w4 & w6 & w7 & w9) |
						(~w0 & ~w1 & ~w3 & w5 & w6 & w7 & w9) |
						(w1 & w2 & w3 & w5 & w6 & w7 & w9) |
						(~w1 & ~w2 & ~w3 & ~w4 & ~w7 & w8 & w9) |
						(w2 & w4 & ~w5 & w6 & w8 & w9) |
						(~w3 & ~w4 & ~w7 & ~w8 & ~w9 & w10) |
						(w3 & w4 & w7 & w8 & ~w10) |
						(w3 & w4 & ~w5 & w6 & w9) |
						(~w4 & w5 & w6 & w7 & w9) |
						(~w6 & ~w7 & ~w8 & ~w9 & w10) |
						(~w5 & ~w7 & ~w8 & ~w9 & w10) |
						(w5 & w7 & w8 & ~w10) | (w6 & w7 & w8 & ~w10) |
						(w5 & w6 & ~w8 & w9) | (~w6 & ~w7 & w8 & w9) |
						(~w5 & ~w7 & w8 & w9) | (w7 & ~w8 & w9) | (w9 & ~w10);
				else if (j == 1)
					r = (w0 & w2 & w4 & w5 & w6 & w7 & w10) |
						(w1 & w2 & w4 & w5 & w6 & w7 & w10) |
						(~w1 & ~w2 & ~w3 & ~w4 & ~w7 & w9 & w10) |
						(w3 & w4 & w5 & w6 & w7 & w10) |
						(w3 & w5 & w6 & ~w8 & w10) |
						(w4 & w5 & w6 & ~w8 & w10) |
						(~w6 & ~w7 & w9 & w10) | (~w5 & ~w7 & w9 & w10) |
						(w7 & ~w8 & w10) | (w8 & ~w9 & w10) | (~w8 & w9 & w10);
				else if (j == 2)
					r = (w1 & w5 & w6 & w8 & w9 & w10) |
						(w2 & w5 & w6 & w8 & w9 & w10) |
						(w3 & w5 & w6 & w8 & w9 & w10) |
						(w4 & w5 & w6 & w8 & w9 & w10) | (w7 & w8 & w9 & w10);
			end
			default: begin
				if (j == 0)
					r = (w0 & w1 & ~w2 & w3 & w4 & ~w6 & w7 & ~w9) |
						(w2 & w3 & w4 & ~w5 & ~w6 & w7 & ~w9) |
						(~w2 & ~w3 & ~w4 & ~w5 & ~w7 & w8) |
						(~w1 & ~w3 & ~w4 & ~w5 & ~w7 & w8) |
						(~w0 & ~w3 & ~w4 & ~w5 & ~w7 & w8) |
						(w0 & ~w2 & w3 & w5 & ~w6 & w8) |
						(w1 & ~w2 & w3 & w5 & ~w6 & w8) |
						(w2 & w3 & ~w4 & w5 & ~w6 & w8) |
						(w0 & w1 & w4 & w5 & w7 & w9) |
						(w2 & ~w3 & w4 & w6 & w7 & w9) |
						(~w2 & w3 & w4 & w6 & w7 & w9) |
						(~w3 & w5 & ~w6 & w7 & ~w9) |
						(w0 & w2 & w5 & w7 & ~w8) | (w1 & w2 & w5 & w7 & ~w8) |
						(w4 & w5 & ~w6 & w7 & w9) | (~w4 & ~w5 & w6 & w7 & w9) |
						(~w2 & ~w5 & w6 & w7 & w9) |
						(w3 & w5 & w7 & ~w8) | (~w5 & ~w6 & w8 & ~w9) |
						(~w2 & ~w6 & w8 & ~w9) | (w6 & w7 & ~w8) |
						(~w7 & w8 & ~w9) | (~w6 & ~w7 & w8);
				else if (j == 1)
					r = (w2 & w3 & w4 & w5 & w7 & w8 & ~w9) |
						(w2 & w3 & w4 & ~w5 & w6 & w7 & w9) |
						(~w2 & ~w3 & ~w4 & ~w5 & ~w7 & w9) |
						(~w1 & ~w3 & ~w4 & ~w5 & ~w7 & w9) |
						(~w0 & ~w3 & ~w4 & ~w5 & ~w7 & w9) |
						(~w4 & w5 & w6 & w7 & w9) | (~w3 & w5 & w6 & w7 & w9) |
						(~w2 & w5 & w6 & w7 & w9) |
						(w6 & w7 & w8 & ~w9) | (~w6 & ~w7 & w9) | (~w8 & w9);
				else if (j == 2)
					r = (w0 & w1 & w2 & ~w3 & w6 & w8 & w9) |
						(w3 & w6 & ~w7 & w8 & w9) | (w4 & ~w5 & w6 & w8 & w9) |
						(~w3 & w5 & w6 & w8 & w9) |
						(~w6 & w7 & w8 & w9) | (~w4 & w7 & w8 & w9) |
						(~w2 & w7 & w8 & w9);
				else
					r = w2 & w3 & w4 & w5 & w6 & w7 & w8 & w9;
			end
		endcase
		return r;
	endfunction

	// Take one accepted word into the group; on the last word queue 64 coefficients.
	task automatic absorb_word(input logic [63:0] word);
		logic [63:0] p0, p1, p2, p3, signs;
		logic [15:0] v;
		logic [3:0]  m;
		coeff_item_t it;
		int len;
		len = words_in_group(cur_set);
		grp_words[grp_fill] = word;
		grp_fill++;
		if (grp_fill >= len) begin
			grp_fill = 0;
			p0 = mag_plane(cur_set, 0);
			p1 = mag_plane(cur_set, 1);
			p2 = mag_plane(cur_set, 2);
			p3 = mag_plane(cur_set, 3);
			signs = grp_words[len-1];
			for (int k = 0; k < 64; k++) begin
				m = {p3[k], p2[k], p1[k], p0[k]};
				v = signs[k] ? (16'd0 - {12'd0, m}) : {12'd0, m};
				it.coeff = v << cur_shift;
				it.last = (k == 63);
				coeff_queue.push_back(it);
			end
		end
	endtask

	// Prediction on each accepted word.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			absorb_word(s_axis_tdata);
			took = 1'b1;
		end
	end

	// Word driver: presents the next queued word with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			took = 1'b0;
		end else if (!s_axis_tvalid || took) begin
			took = 1'b0;
			if (word_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				s_axis_tdata  <= word_queue.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// Coefficient monitor.
	always @(posedge clk) begin
		coeff_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (coeff_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected coefficient %h last %b", m_axis_tdata,
						m_axis_tlast);
			end else begin
				want = coeff_queue.pop_front();
				coeffs_seen++;
				if (want.last)
					groups_seen++;
				if (want.coeff !== m_axis_tdata || want.last !== m_axis_tlast) begin
					errors++;
					if (errors <= 10)
						$display("tb: mismatch coeff exp %h got %h, last exp %b got %b",
							want.coeff, m_axis_tdata, want.last, m_axis_tlast);
				end
			end
		end
	end

	// Wait until every word has gone in and every coefficient has come out.
	// Checked at the rising edge, where the driver never changes its outputs.
	task automatic drain();
		do @(posedge clk);
		while (word_queue.size() != 0 || s_axis_tvalid || coeff_queue.size() != 0);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SHIFT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NOISE_SET) begin
			cur_set  = val[SET_W-1:0];
			grp_fill = 0;
		end else begin
			cur_shift = val;
		end
	endtask

	// Random words biased so that dense and sparse lanes both occur.
	function automatic logic [63:0] pick_word();
		logic [63:0] a, b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return a | b;
			3: return a & b;
			default: return a;
		endcase
	endfunction

	initial begin
		int nwords;
		cfg_we        = 1'b0;
		cfg_index     = REG_NOISE_SET;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		took          = 1'b0;
		errors        = 0;
		groups_seen   = 0;
		coeffs_seen   = 0;
		grp_fill      = 0;
		cur_set       = SET_D1;
		cur_shift     = SHIFT_RESET;
		src_idle_pct  = 33;
		dst_idle_pct  = 71;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a D1 group of all ones with alternating signs, reset settings.
		for (int i = 0; i < 9; i++)
			word_queue.push_back('1);
		word_queue.push_back(64'haaaa_aaaa_5555_5555);
		drain();
		// A partial group is dropped by a set change.
		for (int i = 0; i < 3; i++)
			word_queue.push_back({$urandom, $urandom});
		drain();
		write_reg(REG_NOISE_SET, SHIFT_W'(SET_D4));
		// D4 group of all ones; the shift changes half way and the new one counts.
		for (int i = 0; i < 5; i++)
			word_queue.push_back('1);
		drain();
		write_reg(REG_COEFF_SHIFT, 4'd15);
		for (int i = 0; i < 5; i++)
			word_queue.push_back('1);
		word_queue.push_back(64'hffff_0000_ffff_0000);
		drain();

		// Random phases over every set and the shift extremes.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				src_idle_pct = 71;
				dst_idle_pct = 33;
			end else if (ph == 8) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			write_reg(REG_NOISE_SET, SHIFT_W'(ph % 4));
			if (ph % 3 == 0)
				write_reg(REG_COEFF_SHIFT, 4'd0);
			else if (ph % 3 == 1)
				write_reg(REG_COEFF_SHIFT, 4'd15);
			else
				write_reg(REG_COEFF_SHIFT, SHIFT_W'($urandom_range(0, 15)));
			nwords = words_in_group(cur_set) * 3;
			if (ph % 4 == 1)
				nwords += $urandom_range(1, 4);
			for (int i = 0; i < nwords; i++)
				word_queue.push_back(pick_word());
			drain();
		end

		$display("tb: %0d groups, %0d coefficients checked over all four noise sets",
			groups_seen, coeffs_seen);
		$display("tb: shifts 0, 15 and random, mid-group set and shift changes");
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
